[hw/rtl/spg_pkg.sv]
// Shared types and constants for the sine plasma pixel generator.
// Used by spg_wave and the top level; depends on nothing else.
package spg_pkg;

   localparam int PHASE_W    = 24;
   localparam int SINE_W     = 16;
   localparam int COORD_W    = 12;
   localparam int AMP_W      = 12;
   localparam int ENTRY_W    = 10;
   localparam int COLOR_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Sine table generation: pi in Q30, Q1.15 peak, offset that makes the sample unsigned
   localparam longint unsigned PI_Q30    = 64'd3373259426;
   localparam longint unsigned SINE_PEAK = 64'd32767;
   localparam longint unsigned SINE_BIAS = 64'd32768;
   localparam longint unsigned Q30_HALF  = 64'd536870912;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_RENDER = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_STEP   = 3'd0,
      CSR_X_WAVE_AMP  = 3'd1,
      CSR_X_WAVE_STEP = 3'd2,
      CSR_X_PHASE     = 3'd3,
      CSR_Y_WAVE_AMP  = 3'd4,
      CSR_Y_WAVE_STEP = 3'd5,
      CSR_Y_PHASE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [COORD_W-1:0]   pixel_x;
      logic [COORD_W-1:0]   pixel_y;
      logic [ENTRY_W-1:0]   entry_index;
      logic [COLOR_W-1:0]   entry_color;
   } spg_item_type;

endpackage

[hw/rtl/spg_wave.sv]
// Three-stage sine wave unit: phase multiply, table address, sine table read.
// Output is the Q1.15 sample offset by 32768. Depends on spg_pkg.
module spg_wave
   import spg_pkg::*;
#(
   parameter int SINE_ENTRIES = 1024,
   parameter int V_WIDTH      = 12
) (
   input  logic                clock,
   input  logic [2:0]          stage_en,
   input  logic [V_WIDTH-1:0]  v,
   input  logic [PHASE_W-1:0]  step,
   output logic [SINE_W-1:0]   sine
);

   localparam int ADDR_W  = $clog2(SINE_ENTRIES);
   localparam int PPROD_W = V_WIDTH + PHASE_W;
   localparam int APROD_W = PHASE_W + ADDR_W + 1;

   logic [SINE_W-1:0]  sine_lut [SINE_ENTRIES];

   logic [PPROD_W-1:0] phase_prod;
   logic [APROD_W-1:0] addr_prod;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [SINE_W-1:0]  sine_ff, sine_in;

   // Table built at elaboration: fold to a quarter wave, odd Taylor series in Q30
   for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_lut
      localparam longint unsigned NUM = SINE_ENTRIES;
      localparam longint unsigned R0  = k;
      localparam bit              NEG = (2 * R0) > NUM;
      localparam longint unsigned R   = NEG ? (NUM - R0) : R0;
      localparam longint unsigned U   = ((4 * R) > NUM) ? (NUM - 2 * R) : (2 * R);
      localparam longint unsigned X   = (PI_Q30 * U) / SINE_ENTRIES;
      localparam longint unsigned T1  = ((((X * X) >> 30) * X) >> 30) / 6;
      localparam longint unsigned S1  = (X >= T1) ? (X - T1) : 0;
      localparam longint unsigned T2  = ((((T1 * X) >> 30) * X) >> 30) / 20;
      localparam longint unsigned S2  = S1 + T2;
      localparam longint unsigned T3  = ((((T2 * X) >> 30) * X) >> 30) / 42;
      localparam longint unsigned S3  = (S2 >= T3) ? (S2 - T3) : 0;
      localparam longint unsigned T4  = ((((T3 * X) >> 30) * X) >> 30) / 72;
      localparam longint unsigned S4  = S3 + T4;
      localparam longint unsigned T5  = ((((T4 * X) >> 30) * X) >> 30) / 110;
      localparam longint unsigned S5  = (S4 >= T5) ? (S4 - T5) : 0;
      localparam longint unsigned Q   = (S5 * SINE_PEAK + Q30_HALF) >> 30;
      localparam longint unsigned QC  = (Q > SINE_PEAK) ? SINE_PEAK : Q;
      localparam longint unsigned VAL = NEG ? (SINE_BIAS - QC) : (SINE_BIAS + QC);
      assign sine_lut[k] = SINE_W'(VAL);
   end

   always_comb begin
      phase_prod = PPROD_W'(v) * PPROD_W'(step);
      phase_in   = phase_prod[PHASE_W-1:0];
      addr_prod  = APROD_W'(phase_ff) * APROD_W'(SINE_ENTRIES);
      addr_in    = addr_prod[PHASE_W +: ADDR_W];
      sine_in    = sine_lut[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         phase_ff <= phase_in;
      end
      if (stage_en[1]) begin
         addr_ff <= addr_in;
      end
      if (stage_en[2]) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

[hw/rtl/sine_plasma_pixel_generator.sv]
// Sine plasma pixel generator, built on spg_pkg and spg_wave. Takes one beat per clock on
// req_ unless rsp_ stalls and, for a render beat, presents its palette colour on rsp_ from
// the output register; a load beat writes one palette entry and gives no result. The beats
// pass through the eight-stage pipeline (two three-stage deformation waves, the deformation
// multiply, two three-stage main waves, index sum) followed by the palette RAM, which a load
// writes at the same stage where a render reads it, so beats take effect in order. Stalls on
// rsp_ back up stage by stage and fill bubbles first. Palette entries hold nothing until
// loaded; there is no clearing pass. Write csr_ only while idle.
module sine_plasma_pixel_generator
   import spg_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 1024,
   parameter int SINE_ENTRIES    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [COORD_W-1:0]    req_pixel_x,
   input  logic [COORD_W-1:0]    req_pixel_y,
   input  logic [ENTRY_W-1:0]    req_entry_index,
   input  logic [COLOR_W-1:0]    req_entry_color,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic [ENTRY_W-1:0]    rsp_palette_slot,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STAGES     = 8;
   localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
   localparam int SLOT_W     = PAL_AW + 1;
   localparam int MAIN_SHIFT = SINE_W + 1;
   localparam int BMUL_W     = PAL_AW + 1 + SINE_W;
   localparam int DMUL_W     = AMP_W + SINE_W;
   localparam int MAIN_V_W   = COORD_W + 2;

   // Configuration registers
   logic [PHASE_W-1:0] base_step_ff;
   logic [AMP_W-1:0]   x_amp_ff;
   logic [PHASE_W-1:0] x_step_ff;
   logic [COORD_W-1:0] x_phase_ff;
   logic [AMP_W-1:0]   y_amp_ff;
   logic [PHASE_W-1:0] y_step_ff;
   logic [COORD_W-1:0] y_phase_ff;

   // Pipeline control and carried beat
   logic [STAGES-1:0]  vld_ff, vld_in, stage_en;
   spg_item_type       item_ff [STAGES];
   spg_item_type       item_in [STAGES];
   logic               out_en;

   // Datapath
   logic [SINE_W-1:0]    sine_x, sine_y, sine_a, sine_b;
   logic [DMUL_W-1:0]    wx_prod, wy_prod;
   logic [AMP_W-1:0]     wx_ff, wx_in, wy_ff, wy_in;
   logic [MAIN_V_W-1:0]  main_va, main_vb;
   logic [BMUL_W-1:0]    ba_prod, bb_prod;
   logic [SLOT_W-1:0]    slot_sum, slot_in;
   logic [PAL_AW-1:0]    slot_ff;

   // Output register and palette
   logic                 rsp_valid_ff;
   logic [PAL_AW-1:0]    rsp_slot_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [COLOR_W-1:0]   palette_mem [PALETTE_ENTRIES];
   logic                 pal_wr;
   logic [PAL_AW-1:0]    pal_waddr;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= '0;
         x_amp_ff     <= '0;
         x_step_ff    <= '0;
         x_phase_ff   <= '0;
         y_amp_ff     <= '0;
         y_step_ff    <= '0;
         y_phase_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_STEP:   base_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_X_WAVE_AMP:  x_amp_ff     <= csr_wdata[AMP_W-1:0];
            CSR_X_WAVE_STEP: x_step_ff    <= csr_wdata[PHASE_W-1:0];
            CSR_X_PHASE:     x_phase_ff   <= csr_wdata[COORD_W-1:0];
            CSR_Y_WAVE_AMP:  y_amp_ff     <= csr_wdata[AMP_W-1:0];
            CSR_Y_WAVE_STEP: y_step_ff    <= csr_wdata[PHASE_W-1:0];
            CSR_Y_PHASE:     y_phase_ff   <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // A stage advances when it is empty or the stage after it advances.
   assign out_en               = !rsp_valid_ff || rsp_ready;
   assign stage_en[STAGES-1]   = !vld_ff[STAGES-1] || out_en;
   for (genvar i = 0; i < STAGES - 1; i++) begin : g_en
      assign stage_en[i] = !vld_ff[i] || stage_en[i+1];
   end

   assign req_ready = stage_en[0];
   assign vld_in    = {vld_ff[STAGES-2:0], req_valid};

   always_comb begin
      item_in[0].kind        = req_kind_type'(req_type);
      item_in[0].pixel_x     = req_pixel_x;
      item_in[0].pixel_y     = req_pixel_y;
      item_in[0].entry_index = req_entry_index;
      item_in[0].entry_color = req_entry_color;
      for (int i = 1; i < STAGES; i++) begin
         item_in[i] = item_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (stage_en[i]) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- deformation waves
   spg_wave #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .V_WIDTH      (COORD_W)
   ) u_wave_x (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .v        (req_pixel_x),
      .step     (x_step_ff),
      .sine     (sine_x)
   );

   spg_wave #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .V_WIDTH      (COORD_W)
   ) u_wave_y (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .v        (req_pixel_y),
      .step     (y_step_ff),
      .sine     (sine_y)
   );

   always_comb begin
      wx_prod = DMUL_W'(x_amp_ff) * DMUL_W'(sine_x);
      wy_prod = DMUL_W'(y_amp_ff) * DMUL_W'(sine_y);
      wx_in   = wx_prod[DMUL_W-1:SINE_W];
      wy_in   = wy_prod[DMUL_W-1:SINE_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   // ---------------------------------------------------------------- main waves
   // Row argument takes the x deformation and vice versa.
   assign main_va = MAIN_V_W'(item_ff[3].pixel_y) + MAIN_V_W'(y_phase_ff) + MAIN_V_W'(wx_ff);
   assign main_vb = MAIN_V_W'(item_ff[3].pixel_x) + MAIN_V_W'(x_phase_ff) + MAIN_V_W'(wy_ff);

   spg_wave #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .V_WIDTH      (MAIN_V_W)
   ) u_wave_a (
      .clock    (clock),
      .stage_en (stage_en[6:4]),
      .v        (main_va),
      .step     (base_step_ff),
      .sine     (sine_a)
   );

   spg_wave #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .V_WIDTH      (MAIN_V_W)
   ) u_wave_b (
      .clock    (clock),
      .stage_en (stage_en[6:4]),
      .v        (main_vb),
      .step     (base_step_ff),
      .sine     (sine_b)
   );

   // ---------------------------------------------------------------- palette index
   always_comb begin
      ba_prod  = BMUL_W'(PALETTE_ENTRIES) * BMUL_W'(sine_a);
      bb_prod  = BMUL_W'(PALETTE_ENTRIES) * BMUL_W'(sine_b);
      slot_sum = SLOT_W'(ba_prod[BMUL_W-1:MAIN_SHIFT]) + SLOT_W'(bb_prod[BMUL_W-1:MAIN_SHIFT]);
      // clamp to the last palette entry
      if (slot_sum > SLOT_W'(PALETTE_ENTRIES - 1)) begin
         slot_in = SLOT_W'(PALETTE_ENTRIES - 1);
      end else begin
         slot_in = slot_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         slot_ff <= PAL_AW'(slot_in);
      end
   end

   // ---------------------------------------------------------------- palette and output
   // Drop loads that address beyond the palette.
   assign pal_wr    = out_en && vld_ff[STAGES-1] && (item_ff[STAGES-1].kind == REQ_LOAD) &&
                      (32'(item_ff[STAGES-1].entry_index) < 32'(PALETTE_ENTRIES));
   assign pal_waddr = PAL_AW'(item_ff[STAGES-1].entry_index);

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         palette_mem[pal_waddr] <= item_ff[STAGES-1].entry_color;
      end
      if (out_en) begin
         rsp_color_ff <= palette_mem[slot_ff];
         rsp_slot_ff  <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= vld_ff[STAGES-1] && (item_ff[STAGES-1].kind == REQ_RENDER);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_palette_slot = ENTRY_W'(rsp_slot_ff);

`ifndef ASSERT_OFF
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while the whole pipeline is stalled");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (out_en && vld_ff[STAGES-1] && (item_ff[STAGES-1].kind == REQ_LOAD)) |=> !rsp_valid)
      else $error("palette load produced a result beat");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_slot_ff) < 32'(PALETTE_ENTRIES)))
      else $error("palette index beyond the last entry");
`endif

endmodule
